[hw/rtl/mlbt_pkg.sv]
// Shared types and constants for the multi-channel LED blink timer.
// No dependencies.
`default_nettype none

package mlbt_pkg;

  localparam int unsigned CH_IDX_W = 4;   // channel field width
  localparam int unsigned CNT_W    = 8;   // countdown / reload width
  localparam int unsigned LED_W    = 12;  // led_levels field width
  localparam int unsigned MAX_CH   = 16;  // largest bank the channel field can address

  localparam int unsigned IN_DATA_W  = 24; // channel + delay + period, padded to bytes
  localparam int unsigned OUT_DATA_W = 16; // led_levels, padded to bytes

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

  // Per-channel update strobes for one processed item.
  typedef struct packed {
    logic tick;  // decrement running countdowns
    logic set;   // load this channel
  } chan_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/mlbt_chan.sv]
// One LED channel: countdown, reload, phase and lit state with its update logic.
// Depends on mlbt_pkg.
`default_nettype none

module mlbt_chan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mlbt_pkg::chan_ctrl_t          ctrl,
  input  wire logic [mlbt_pkg::CNT_W-1:0]    delay,
  input  wire logic [mlbt_pkg::CNT_W-1:0]    period,
  output logic                               lit_nxt
);
  import mlbt_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_dec;
  logic [CNT_W-1:0] reload_r, reload_nxt;
  logic             phase_r, phase_nxt;
  logic             lit_r;

  assign cnt_dec = cnt_r - CNT_W'(1);

  always_comb begin
    cnt_nxt    = cnt_r;
    reload_nxt = reload_r;
    phase_nxt  = phase_r;
    lit_nxt    = lit_r;
    if (ctrl.set) begin
      cnt_nxt    = delay;
      reload_nxt = period;
      lit_nxt    = 1'b1;
    end else if (ctrl.tick && (cnt_r != '0)) begin
      cnt_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        if (reload_r != '0) begin
          // expiry with reload: show old phase, then flip it
          cnt_nxt   = reload_r;
          lit_nxt   = phase_r;
          phase_nxt = ~phase_r;
        end else begin
          lit_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      reload_r <= '0;
      phase_r  <= 1'b0;
      lit_r    <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      reload_r <= reload_nxt;
      phase_r  <= phase_nxt;
      lit_r    <= lit_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/multi_led_blink_timer_top.sv]
// Top level of the multi-channel LED blink timer: input register, channel bank,
// result register. Depends on mlbt_pkg and mlbt_chan.
`default_nettype none

// Usage
//   Input stream (in_*): one transfer is one command. in_tuser = cmd
//   (0 = tick, 1 = set). For a set, in_tdata carries the channel, the first
//   delay and the reload period. A tick decrements every running countdown;
//   on expiry a channel with a reload reloads and shows its phase bit (which
//   then flips), a channel without one goes dark. A set to a channel at or
//   beyond CHANNELS changes nothing.
//   Output stream (out_*): exactly one transfer per command, the LED vector
//   after that command, in command order.
// Timing
//   The command sits in the input register, then the whole bank updates in
//   parallel and the LED vector lands in the result register, which drives
//   out_tvalid. Throughput is one command per cycle while out_tready is high,
//   set by the parallel channel update.
// Reset
//   Synchronous, active low: all countdowns, reloads and phase bits clear,
//   all LEDs off, both registers empty.
// Stall
//   While out_tready is low a held result keeps its value; the input register
//   still takes one more command, after which in_tready drops until the
//   result is taken.

module multi_led_blink_timer_top #(
  parameter int unsigned CHANNELS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [3:0] channel, [11:4] first_delay, [19:12] reload_period, [23:20] zero
  input  wire logic [mlbt_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] cmd
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [11:0] led_levels, [15:12] zero
  output logic [mlbt_pkg::OUT_DATA_W-1:0]        out_tdata
);
  import mlbt_pkg::*;

  // Input register
  logic                s1_valid_r;
  cmd_t                s1_cmd_r;
  logic [CH_IDX_W-1:0] s1_ch_r;
  logic [CNT_W-1:0]    s1_delay_r;
  logic [CNT_W-1:0]    s1_period_r;
  logic                s1_adv;

  // Result register
  logic                out_valid_r;
  logic [LED_W-1:0]    out_leds_r;

  logic [CHANNELS-1:0] lit_nxt;
  logic [LED_W-1:0]    leds_nxt;
  logic                ch_in_range;

  // Stage 1 moves on when the result register is empty or being drained.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r    <= cmd_t'(in_tuser);
      s1_ch_r     <= in_tdata[CH_IDX_W-1:0];
      s1_delay_r  <= in_tdata[CH_IDX_W +: CNT_W];
      s1_period_r <= in_tdata[CH_IDX_W+CNT_W +: CNT_W];
    end
  end

  // Out-of-range channels are dropped here so no cell sees a set.
  assign ch_in_range = ({1'b0, s1_ch_r} < (CH_IDX_W+1)'(CHANNELS));

  genvar gi;
  generate
    for (gi = 0; gi < CHANNELS; gi++) begin : g_chan
      chan_ctrl_t ctrl;
      assign ctrl.tick = s1_adv && (s1_cmd_r == CMD_TICK);
      assign ctrl.set  = s1_adv && (s1_cmd_r == CMD_SET) && ch_in_range
                         && (s1_ch_r == CH_IDX_W'(gi));
      mlbt_chan u_chan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .delay   (s1_delay_r),
        .period  (s1_period_r),
        .lit_nxt (lit_nxt[gi])
      );
    end

    // Channels beyond the 12-bit field run but are not shown; missing ones read dark.
    for (gi = 0; gi < LED_W; gi++) begin : g_led
      if (gi < CHANNELS) begin : g_on
        assign leds_nxt[gi] = lit_nxt[gi];
      end else begin : g_off
        assign leds_nxt[gi] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_leds_r <= leds_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-LED_W)'(0), out_leds_r};

endmodule

`default_nettype wire

[verif/multi_led_blink_timer_top_test.sv]
// Self-checking testbench for multi_led_blink_timer_top: directed and random tick/set traffic.
// It predicts the LED vector after each command and checks every output transfer.
// Depends on mlbt_pkg and the RTL of the block.
`timescale 1ns / 1ps

module multi_led_blink_timer_top_test;
  import mlbt_pkg::*;

  localparam int unsigned CHANNELS    = 12;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [3:0] channel, [11:4] first_delay, [19:12] reload_period, [23:20] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [0] cmd
  logic                  in_tuser = CMD_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [11:0] led_levels, [15:12] zero
  logic [OUT_DATA_W-1:0] out_tdata;

  multi_led_blink_timer_top #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // Mirror of the channel bank, updated once per accepted command.
  logic [CNT_W-1:0] count_left [CHANNELS];
  logic [CNT_W-1:0] reload_len [CHANNELS];
  logic             phase_bit  [CHANNELS];
  logic             led_on     [CHANNELS];

  // LED vectors still owed by the block, oldest first.
  logic [LED_W-1:0] led_levels_q [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          send_gaps      = 1'b0;  // random holes between input transfers
  bit          stall_on       = 1'b0;  // random back-pressure on the output

  logic [LED_W-1:0] want_levels;

  // Mostly zero, sometimes a few cycles, rarely a long hole.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Short counts dominate so channels expire often; full range keeps every bit moving.
  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return CNT_W'($urandom_range(0, 4));
    if (r < 85) return CNT_W'($urandom_range(5, 20));
    return CNT_W'($urandom_range(0, 255));
  endfunction

  function automatic void clear_bank();
    for (int i = 0; i < CHANNELS; i++) begin
      count_left[i] = '0;
      reload_len[i] = '0;
      phase_bit[i]  = 1'b0;
      led_on[i]     = 1'b0;
    end
  endfunction

  // Applies one command to the mirror and returns the LED vector after it.
  function automatic logic [LED_W-1:0] bank_step(cmd_t cmd, logic [CH_IDX_W-1:0] ch,
                                                 logic [CNT_W-1:0] delay,
                                                 logic [CNT_W-1:0] period);
    logic [LED_W-1:0] levels;
    if (cmd == CMD_SET) begin
      // out-of-range channel: nothing changes
      if (ch < CHANNELS) begin
        count_left[ch] = delay;
        reload_len[ch] = period;
        led_on[ch]     = 1'b1;  // phase is left alone on purpose
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (count_left[i] != 0) begin
          count_left[i] = count_left[i] - 1'b1;
          if (count_left[i] == 0) begin
            if (reload_len[i] != 0) begin
              count_left[i] = reload_len[i];
              led_on[i]     = phase_bit[i];
              phase_bit[i]  = ~phase_bit[i];
            end else begin
              led_on[i] = 1'b0;
            end
          end
        end
      end
    end
    levels = '0;
    for (int i = 0; i < CHANNELS && i < LED_W; i++) levels[i] = led_on[i];
    return levels;
  endfunction

  // One input transfer. tvalid stays high on return so back-to-back commands
  // never drop it; it is only lowered when a hole is inserted.
  task automatic push_cmd(input cmd_t cmd, input logic [CH_IDX_W-1:0] ch,
                          input logic [CNT_W-1:0] delay, input logic [CNT_W-1:0] period);
    int unsigned gap;
    gap = send_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'h0, period, delay, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    led_levels_q.push_back(bank_step(cmd, ch, delay, period));
  endtask

  // Tick with junk in the unused fields, then a clean one: nothing may light.
  task automatic test_idle_tick();
    push_cmd(CMD_TICK, 4'hF, 8'hFF, 8'hFF);
    push_cmd(CMD_TICK, 4'h0, 8'h00, 8'h00);
  endtask

  // Extremes of channel, delay and period; sets beyond the bank are dropped.
  task automatic test_set_bounds();
    push_cmd(CMD_SET, 4'd0, 8'd0, 8'd0);        // zero delay: lit for good
    push_cmd(CMD_SET, 4'd11, 8'hFF, 8'hFF);
    push_cmd(CMD_SET, 4'd12, 8'd1, 8'd1);       // first index past the bank
    push_cmd(CMD_SET, 4'd15, 8'hFF, 8'hFF);
    push_cmd(CMD_TICK, 4'd12, 8'h00, 8'h00);
  endtask

  // Zero reload: LED goes dark at expiry.
  task automatic test_one_shot();
    push_cmd(CMD_SET, 4'd5, 8'd1, 8'd0);
    push_cmd(CMD_TICK, 4'd5, 8'd1, 8'd0);
    push_cmd(CMD_SET, 4'd10, 8'd2, 8'd0);
    push_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0);
    push_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0);
  endtask

  // Reload toggles through the phase bit; a second set keeps the phase.
  task automatic test_periodic_toggle();
    push_cmd(CMD_SET, 4'd3, 8'd1, 8'd1);
    repeat (3) push_cmd(CMD_TICK, 4'd3, 8'h55, 8'hAA);
    push_cmd(CMD_SET, 4'd3, 8'd2, 8'd2);
    repeat (2) push_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0);
    push_cmd(CMD_SET, 4'd7, 8'd1, 8'hFF);
    push_cmd(CMD_TICK, 4'd7, 8'd0, 8'd0);
  endtask

  // Random mix weighted toward ticks and short counts so most channels cycle.
  task automatic test_random_blink(input int unsigned n_items, input bit idle);
    logic [CH_IDX_W-1:0] ch;
    send_gaps = idle;
    stall_on  = idle;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 85) ch = CH_IDX_W'($urandom_range(0, CHANNELS - 1));
      else ch = CH_IDX_W'($urandom_range(CHANNELS, MAX_CH - 1));
      if ($urandom_range(0, 99) < 68)
        push_cmd(CMD_TICK, CH_IDX_W'($urandom), CNT_W'($urandom), CNT_W'($urandom));
      else
        push_cmd(CMD_SET, ch, pick_count(), pick_count());
    end
  endtask

  // Output back-pressure: ready bursts broken by holes of random length.
  initial begin
    forever begin
      int unsigned gap;
      gap = stall_on ? pick_gap() : 0;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Result checker: each output transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (led_levels_q.size() == 0) begin
        $error("led_levels: no transfer expected, got %03h", out_tdata[LED_W-1:0]);
        mismatch_count++;
      end else begin
        want_levels = led_levels_q.pop_front();
        if (out_tdata[LED_W-1:0] !== want_levels) begin
          $error("led_levels: expected %03h, got %03h", want_levels, out_tdata[LED_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[OUT_DATA_W-1:LED_W] !== '0) begin
          $error("out_tdata padding: expected 0, got %h", out_tdata[OUT_DATA_W-1:LED_W]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multi_led_blink_timer_top_test: FAIL");
      $finish;
    end
  end

  initial begin
    clear_bank();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_tick();
    test_set_bounds();
    test_one_shot();
    test_periodic_toggle();
    test_random_blink(300, 1'b0);   // full rate, no stalls
    test_random_blink(1150, 1'b1);  // holes and back-pressure on both sides

    // Drain: stop sending, release the output and let the pipe empty.
    in_tvalid <= 1'b0;
    stall_on  = 1'b0;
    while (led_levels_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("multi_led_blink_timer_top_test: PASS");
    end else begin
      $display("multi_led_blink_timer_top_test: FAIL");
    end
    $finish;
  end

endmodule
